[design/assert_macros.svh]
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define CABE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cabe assertion failed");

// Check that a condition never holds outside reset
`define CABE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cabe forbidden condition seen");

`endif

[design/cabe_pkg.sv]
// Types, decode tables and helper functions for the conditional ALU/branch executor
package cabe_pkg;

  localparam int NumRegs   = 16;
  localparam int NumClass  = 15;
  localparam logic [3:0] PcIdx   = 4'd15;
  localparam logic [3:0] LinkIdx = 4'd14;
  localparam logic [31:0] BrOffMask = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    OUT_DP    = 2'd0,
    OUT_BR    = 2'd1,
    OUT_CFAIL = 2'd2,
    OUT_UNSUP = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    KIND_DP = 2'd0,
    KIND_BR = 2'd1,
    KIND_NO = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } dp_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_t;

  // Result of the data-processing unit
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  nzcv;
    logic        wr_en;
  } alu_res_t;

  typedef struct packed {
    outcome_t    outcome;
    logic        dest_valid;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] next_pc;
    logic [3:0]  flags_nzcv;
  } result_t;

  localparam logic [31:0] ClsMask [NumClass] = '{
    32'h0FBF0FFF, 32'h0FBFFFF0, 32'h0FB00FF0, 32'h0DBFF000, 32'h0FC000F0,
    32'h0F8000F0, 32'h0E0000F0, 32'h0F000010, 32'h0F000010, 32'h0E000010,
    32'h0F000000, 32'h0E000000, 32'h0E000000, 32'h0C000000, 32'h0C000000};
  localparam logic [31:0] ClsVal [NumClass] = '{
    32'h010F0FFF, 32'h0129F000, 32'h01000090, 32'h0128F000, 32'h00000090,
    32'h00800090, 32'h0C200000, 32'h0E000000, 32'h0E000010, 32'h06000010,
    32'h0F000000, 32'h0E000000, 32'h0A000000, 32'h00000000, 32'h04000000};
  localparam kind_t ClsKind [NumClass] = '{
    KIND_NO, KIND_NO, KIND_NO, KIND_NO, KIND_NO, KIND_NO, KIND_NO, KIND_NO,
    KIND_NO, KIND_NO, KIND_NO, KIND_NO, KIND_BR, KIND_DP, KIND_NO};

  // Test the condition field against the NZCV flags
  function automatic logic cond_pass(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, c, v, res;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    unique case (cond_t'(cc))
      CC_EQ:   res = z;
      CC_NE:   res = !z;
      CC_CS:   res = c;
      CC_CC:   res = !c;
      CC_MI:   res = n;
      CC_PL:   res = !n;
      CC_VS:   res = v;
      CC_VC:   res = !v;
      CC_HI:   res = c && !z;
      CC_LS:   res = !c || z;
      CC_GE:   res = (n == v);
      CC_LT:   res = (n != v);
      CC_GT:   res = !z && (n == v);
      CC_LE:   res = z || (n != v);
      CC_AL:   res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  // First matching entry of the class table wins
  function automatic kind_t classify(input logic [31:0] w);
    kind_t k;
    logic  found;
    k = KIND_NO;
    found = 1'b0;
    for (int i = 0; i < NumClass; i++) begin
      if (!found && ((w & ClsMask[i]) == ClsVal[i])) begin
        k = ClsKind[i];
        found = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

[design/cabe_if.sv]
// Valid/ready channel interfaces for instruction and result transactions
interface cabe_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface cabe_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic        dest_valid;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] next_pc;
  logic [3:0]  flags_nzcv;

  modport source (output valid, output outcome, output dest_valid, output dest_index,
                  output dest_value, output next_pc, output flags_nzcv, input ready);
  modport sink   (input valid, input outcome, input dest_valid, input dest_index,
                  input dest_value, input next_pc, input flags_nzcv, output ready);
endinterface

[design/cabe_alu.sv]
// Barrel shifter and ALU for one data-processing instruction
module cabe_alu
  import cabe_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] rn_val,
  input  logic [31:0] rm_val,
  input  logic [31:0] rs_val,
  input  logic [3:0]  flags,
  output alu_res_t    res
);

  logic        cin;
  logic [31:0] op2;
  logic        sh_c;
  logic [7:0]  amt;
  logic        regform;
  shift_t      sh_type;
  logic [63:0] wide;
  logic [4:0]  rot;
  logic [63:0] imm_wide;
  logic [31:0] add_x, add_y;
  logic        add_ci;
  logic [32:0] sum;
  logic        arith;
  logic [31:0] r;
  logic        c_out, v_out;
  dp_op_t      op;

  assign cin     = flags[1];
  assign regform = instr[4];
  assign sh_type = shift_t'(instr[6:5]);
  assign amt     = regform ? rs_val[7:0] : {3'b000, instr[11:7]};
  assign rot     = {instr[11:8], 1'b0};
  assign op      = dp_op_t'(instr[24:21]);

  // Build operand two: rotated immediate or shifted register
  always_comb begin
    op2      = rm_val;
    sh_c     = cin;
    wide     = '0;
    imm_wide = {24'h0, instr[7:0], 24'h0, instr[7:0]} >> rot;
    if (instr[25]) begin
      op2 = imm_wide[31:0];
      if (rot != 5'd0) sh_c = op2[31];
    end else if (regform && amt == 8'd0) begin
      op2 = rm_val;
    end else begin
      case (sh_type)
        SH_LSL: begin
          if (amt == 8'd0) begin
            op2 = rm_val;
          end else if (amt <= 8'd32) begin
            wide = {32'h0, rm_val} << amt[5:0];
            op2  = wide[31:0];
            sh_c = wide[32];
          end else begin
            op2  = '0;
            sh_c = 1'b0;
          end
        end
        SH_LSR: begin
          if (amt == 8'd0 || amt == 8'd32) begin
            op2  = '0;
            sh_c = rm_val[31];
          end else if (amt < 8'd32) begin
            wide = {rm_val, 32'h0} >> amt[5:0];
            op2  = wide[63:32];
            sh_c = wide[31];
          end else begin
            op2  = '0;
            sh_c = 1'b0;
          end
        end
        SH_ASR: begin
          if (amt == 8'd0 || amt >= 8'd32) begin
            op2  = {32{rm_val[31]}};
            sh_c = rm_val[31];
          end else begin
            wide = $signed({rm_val, 32'h0}) >>> amt[5:0];
            op2  = wide[63:32];
            sh_c = wide[31];
          end
        end
        default: begin
          if (amt == 8'd0) begin
            // Rotate right extended through carry
            op2  = {cin, rm_val[31:1]};
            sh_c = rm_val[0];
          end else if (amt[4:0] == 5'd0) begin
            op2  = rm_val;
            sh_c = rm_val[31];
          end else begin
            wide = {rm_val, rm_val} >> amt[4:0];
            op2  = wide[31:0];
            sh_c = wide[31];
          end
        end
      endcase
    end
  end

  // Select adder operands for the arithmetic opcodes
  always_comb begin
    add_x  = rn_val;
    add_y  = op2;
    add_ci = 1'b0;
    arith  = 1'b1;
    case (op)
      OP_SUB, OP_CMP: begin add_y = ~op2; add_ci = 1'b1; end
      OP_RSB:         begin add_x = op2; add_y = ~rn_val; add_ci = 1'b1; end
      OP_ADD, OP_CMN: begin add_ci = 1'b0; end
      OP_ADC:         begin add_ci = cin; end
      OP_SBC:         begin add_y = ~op2; add_ci = cin; end
      OP_RSC:         begin add_x = op2; add_y = ~rn_val; add_ci = cin; end
      default:        arith = 1'b0;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'h0, add_ci};

  // Logical result or adder output, then carry and overflow
  always_comb begin
    case (op)
      OP_AND, OP_TST: r = rn_val & op2;
      OP_EOR, OP_TEQ: r = rn_val ^ op2;
      OP_ORR:         r = rn_val | op2;
      OP_MOV:         r = op2;
      OP_BIC:         r = rn_val & ~op2;
      OP_MVN:         r = ~op2;
      default:        r = sum[31:0];
    endcase
    c_out = arith ? sum[32] : sh_c;
    v_out = arith ? (~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31])) : flags[0];
  end

  assign res.value = r;
  assign res.nzcv  = {r[31], (r == 32'h0), c_out, v_out};
  assign res.wr_en = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);

endmodule

[design/cond_alu_branch_executor_top.sv]
// Top level: instruction register, execute logic, register file and result register
//
// Executes one ARMv3 instruction word per transaction: the PC (r15) advances by 4, the
// condition field is tested against NZCV, data-processing instructions run through the
// barrel shifter and ALU, B/BL update the PC, and other classes report unsupported.
// One instruction per clock is sustained while the sink takes each result: an accepted
// word is loaded into the instruction register, then decode, shift and ALU settle
// combinationally into the result register, which drives the output channel.
// A result held by the sink stalls the instruction register, and with that register
// full the input stalls as well.
// The register file and flags are updated as the result is registered, so each
// instruction sees all effects of the one before it. Reset clears all 16 registers
// and the flags.
module cond_alu_branch_executor_top
  import cabe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  cabe_instr_if.sink    in_ch,
  cabe_result_if.source out_ch
);

  logic [31:0] rf_r [NumRegs];
  logic [3:0]  flags_r;
  logic        ex_valid_r;
  logic [31:0] ir_r;
  logic        out_valid_r;
  result_t     out_r;

  logic        ex_adv;
  logic [31:0] pc_adv;
  logic [31:0] rn_val, rm_val, rs_val;
  logic        pass;
  kind_t       kind;
  alu_res_t    alu;
  logic [3:0]  rd;
  logic [31:0] br_off;
  result_t     res_nxt;
  logic [31:0] pc_nxt;
  logic [3:0]  flags_nxt;
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [31:0] rf_wd;

  assign ex_adv      = ex_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !ex_valid_r || ex_adv;

  // Read operands; r15 reads as the advanced PC
  assign pc_adv = rf_r[PcIdx] + 32'd4;
  assign rn_val = (ir_r[19:16] == PcIdx) ? pc_adv : rf_r[ir_r[19:16]];
  assign rm_val = (ir_r[3:0] == PcIdx)   ? pc_adv : rf_r[ir_r[3:0]];
  assign rs_val = (ir_r[11:8] == PcIdx)  ? pc_adv : rf_r[ir_r[11:8]];
  assign rd     = ir_r[15:12];

  assign pass = cond_pass(ir_r[31:28], flags_r);
  assign kind = classify(ir_r);

  cabe_alu u_alu (
    .instr  (ir_r),
    .rn_val (rn_val),
    .rm_val (rm_val),
    .rs_val (rs_val),
    .flags  (flags_r),
    .res    (alu)
  );

  // Sign-extended word offset for branches
  assign br_off = {{6{ir_r[23]}}, ir_r[23:0], 2'b00};

  // Work out the architectural effect of the instruction
  always_comb begin
    pc_nxt    = pc_adv;
    flags_nxt = flags_r;
    rf_we     = 1'b0;
    rf_wa     = rd;
    rf_wd     = alu.value;
    res_nxt.outcome    = OUT_UNSUP;
    res_nxt.dest_valid = 1'b0;
    res_nxt.dest_index = '0;
    res_nxt.dest_value = '0;
    if (!pass) begin
      res_nxt.outcome = OUT_CFAIL;
    end else if (kind == KIND_BR) begin
      res_nxt.outcome = OUT_BR;
      pc_nxt = pc_adv + br_off + 32'd4;
      if (ir_r[24]) begin
        rf_we = 1'b1;
        rf_wa = LinkIdx;
        rf_wd = pc_adv;
        res_nxt.dest_valid = 1'b1;
        res_nxt.dest_index = LinkIdx;
        res_nxt.dest_value = pc_adv;
      end
    end else if (kind == KIND_DP) begin
      res_nxt.outcome = OUT_DP;
      if (ir_r[20] && rd != PcIdx) flags_nxt = alu.nzcv;
      if (alu.wr_en) begin
        if (rd == PcIdx) begin
          pc_nxt = alu.value;
        end else begin
          rf_we = 1'b1;
          res_nxt.dest_valid = 1'b1;
          res_nxt.dest_index = rd;
          res_nxt.dest_value = alu.value;
        end
      end
    end
    res_nxt.next_pc    = pc_nxt;
    res_nxt.flags_nzcv = flags_nxt;
  end

  // Instruction register: load on acceptance, drop when executed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ex_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) ir_r <= in_ch.instruction_word;
  end

  // Commit architectural state as the result is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) rf_r[i] <= '0;
      flags_r <= '0;
    end else if (ex_adv) begin
      if (rf_we) rf_r[rf_wa] <= rf_wd;
      rf_r[PcIdx] <= pc_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // Result register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ex_adv) out_r <= res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.outcome    = out_r.outcome;
  assign out_ch.dest_valid = out_r.dest_valid;
  assign out_ch.dest_index = out_r.dest_index;
  assign out_ch.dest_value = out_r.dest_value;
  assign out_ch.next_pc    = out_r.next_pc;
  assign out_ch.flags_nzcv = out_r.flags_nzcv;

`include "assert_macros.svh"

  `CABE_NEVER(a_no_pc_dest, out_valid_r && out_r.dest_valid && out_r.dest_index == PcIdx)
  `CABE_NEVER(a_cfail_no_write, out_valid_r && out_r.outcome == OUT_CFAIL && out_r.dest_valid)
  `CABE_ASSERT(a_stall_holds_state, out_valid_r && !out_ch.ready |=> $stable(rf_r[PcIdx]))
  `CABE_ASSERT(a_pc_matches, out_valid_r |-> out_r.next_pc == rf_r[PcIdx] || ex_valid_r)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the conditional ALU/branch executor
`timescale 1ns / 1ps
module testbench;
  import cabe_pkg::*;

  // Predicted result of one instruction
  typedef struct {
    logic [1:0]  outcome;
    logic        dest_valid;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] next_pc;
    logic [3:0]  flags_nzcv;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count = 0;
  bit   stall_hold = 1'b0;
  bit   in_flood = 1'b0;

  cabe_instr_if  in_ch ();
  cabe_result_if out_ch ();

  cond_alu_branch_executor_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Architectural state held by the predictor
  logic [31:0]  arch_regs [16];
  logic [3:0]   arch_nzcv;
  exec_result_t pending_results [$];

  function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, c, v;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    case (cond_t'(cc))
      CC_EQ: return z;
      CC_NE: return !z;
      CC_CS: return c;
      CC_CC: return !c;
      CC_MI: return n;
      CC_PL: return !n;
      CC_VS: return v;
      CC_VC: return !v;
      CC_HI: return c && !z;
      CC_LS: return !c || z;
      CC_GE: return n == v;
      CC_LT: return n != v;
      CC_GT: return !z && (n == v);
      CC_LE: return z || (n != v);
      CC_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Barrel shift; carry is updated in place
  function automatic logic [31:0] barrel(input logic [31:0] v, input shift_t kind,
                                         input int unsigned amt, input bit regform,
                                         inout logic cy);
    logic s;
    s = v[31];
    if (amt == 0 && regform) return v;
    case (kind)
      SH_LSL: begin
        if (amt == 0) return v;
        if (amt < 32) begin
          cy = v[32 - amt];
          return v << amt;
        end
        cy = (amt == 32) ? v[0] : 1'b0;
        return '0;
      end
      SH_LSR: begin
        if (amt == 0) amt = 32;
        if (amt < 32) begin
          cy = v[amt - 1];
          return v >> amt;
        end
        cy = (amt == 32) ? s : 1'b0;
        return '0;
      end
      SH_ASR: begin
        if (amt == 0) amt = 32;
        if (amt < 32) begin
          cy = v[amt - 1];
          return $unsigned($signed(v) >>> amt);
        end
        cy = s;
        return {32{s}};
      end
      default: begin
        if (amt == 0) begin
          barrel = {cy, v[31:1]};
          cy = v[0];
          return barrel;
        end
        amt = amt % 32;
        if (amt == 0) begin
          cy = s;
          return v;
        end
        cy = v[amt - 1];
        return (v >> amt) | (v << (32 - amt));
      end
    endcase
  endfunction

  function automatic logic [31:0] add_with_flags(input logic [31:0] a, input logic [31:0] b,
                                                 input logic cin, output logic cy,
                                                 output logic ov);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cy = s[32];
    ov = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
    return s[31:0];
  endfunction

  // Execute one instruction on the architectural state
  function automatic exec_result_t execute_instr(input logic [31:0] w);
    exec_result_t res;
    kind_t k;
    logic [31:0] a, b, r, off, pc;
    logic cy, ov, cin;
    logic wr, arith;
    logic [3:0] rd;
    int unsigned rot;
    res = '{OUT_UNSUP, 1'b0, 4'd0, 32'd0, 32'd0, 4'd0};
    arch_regs[15] = arch_regs[15] + 32'd4;
    if (!cond_holds(w[31:28], arch_nzcv)) begin
      res.outcome = OUT_CFAIL;
    end else begin
      k = KIND_NO;
      for (int i = NumClass - 1; i >= 0; i--)
        if ((w & ClsMask[i]) == ClsVal[i]) k = ClsKind[i];
      if (k == KIND_BR) begin
        pc = arch_regs[15];
        off = {{8{w[23]}}, w[23:0]};
        if (w[24]) begin
          arch_regs[LinkIdx] = pc;
          res.dest_valid = 1'b1;
          res.dest_index = LinkIdx;
          res.dest_value = pc;
        end
        arch_regs[15] = pc + (off << 2) + 32'd4;
        res.outcome = OUT_BR;
      end else if (k == KIND_DP) begin
        rd = w[15:12];
        a = arch_regs[w[19:16]];
        cin = arch_nzcv[1];
        cy = cin;
        ov = arch_nzcv[0];
        wr = 1'b1;
        arith = 1'b0;
        r = '0;
        if (w[25]) begin
          rot = w[11:8] * 2;
          b = {24'd0, w[7:0]};
          if (rot != 0) begin
            b = (b >> rot) | (b << (32 - rot));
            cy = b[31];
          end
        end else if (w[4]) begin
          b = barrel(arch_regs[w[3:0]], shift_t'(w[6:5]), arch_regs[w[11:8]][7:0], 1'b1, cy);
        end else begin
          b = barrel(arch_regs[w[3:0]], shift_t'(w[6:5]), w[11:7], 1'b0, cy);
        end
        case (dp_op_t'(w[24:21]))
          OP_AND: r = a & b;
          OP_EOR: r = a ^ b;
          OP_SUB: begin r = add_with_flags(a, ~b, 1'b1, cy, ov); arith = 1'b1; end
          OP_RSB: begin r = add_with_flags(b, ~a, 1'b1, cy, ov); arith = 1'b1; end
          OP_ADD: begin r = add_with_flags(a, b, 1'b0, cy, ov); arith = 1'b1; end
          OP_ADC: begin r = add_with_flags(a, b, cin, cy, ov); arith = 1'b1; end
          OP_SBC: begin r = add_with_flags(a, ~b, cin, cy, ov); arith = 1'b1; end
          OP_RSC: begin r = add_with_flags(b, ~a, cin, cy, ov); arith = 1'b1; end
          OP_TST: begin r = a & b; wr = 1'b0; end
          OP_TEQ: begin r = a ^ b; wr = 1'b0; end
          OP_CMP: begin
            r = add_with_flags(a, ~b, 1'b1, cy, ov);
            arith = 1'b1;
            wr = 1'b0;
          end
          OP_CMN: begin
            r = add_with_flags(a, b, 1'b0, cy, ov);
            arith = 1'b1;
            wr = 1'b0;
          end
          OP_ORR: r = a | b;
          OP_MOV: r = b;
          OP_BIC: r = a & ~b;
          default: r = ~b;
        endcase
        if (w[20] && rd != PcIdx)
          arch_nzcv = {r[31], r == 32'd0, cy, arith ? ov : arch_nzcv[0]};
        if (wr) begin
          arch_regs[rd] = r;
          if (rd != PcIdx) begin
            res.dest_valid = 1'b1;
            res.dest_index = rd;
            res.dest_value = r;
          end
        end
        res.outcome = OUT_DP;
      end
    end
    res.next_pc = arch_regs[15];
    res.flags_nzcv = arch_nzcv;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offer one instruction and hold it until the transaction completes
  task automatic send_instr(input logic [31:0] w);
    int unsigned g;
    g = in_flood ? 0 : gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instruction_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(execute_instr(w));
  endtask

  // Drop valid, hold until every predicted result has been consumed, then settle
  task automatic drain();
    int unsigned guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Receiver ready: random stalls, or a long hold-off on request
  initial begin
    int unsigned g;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_hold) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        stall_hold = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // Compare each completed result transaction with the oldest prediction
  always @(posedge clk) begin
    exec_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.outcome !== e.outcome) begin
          $error("outcome exp %0d got %0d", e.outcome, out_ch.outcome);
          fail_count++;
        end
        if (out_ch.dest_valid !== e.dest_valid) begin
          $error("dest_valid exp %0d got %0d", e.dest_valid, out_ch.dest_valid);
          fail_count++;
        end
        if (out_ch.dest_index !== e.dest_index) begin
          $error("dest_index exp %0d got %0d", e.dest_index, out_ch.dest_index);
          fail_count++;
        end
        if (out_ch.dest_value !== e.dest_value) begin
          $error("dest_value exp %h got %h", e.dest_value, out_ch.dest_value);
          fail_count++;
        end
        if (out_ch.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, out_ch.next_pc);
          fail_count++;
        end
        if (out_ch.flags_nzcv !== e.flags_nzcv) begin
          $error("flags_nzcv exp %h got %h", e.flags_nzcv, out_ch.flags_nzcv);
          fail_count++;
        end
      end
    end
  end

  // Data-processing word builder
  function automatic logic [31:0] dp_word(input cond_t cc, input bit imm, input dp_op_t op,
                                          input bit s, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic [11:0] op2);
    return {cc, 2'b00, imm, op, s, rn, rd, op2};
  endfunction

  // Random data-processing word with mixed operand forms
  function automatic logic [31:0] rand_dp();
    logic [31:0] w;
    w = $urandom();
    w[27:26] = 2'b00;
    if ($urandom_range(3) != 0) w[31:28] = CC_AL;
    if (!w[25] && w[4]) w[7] = 1'b0;
    if ($urandom_range(7) != 0 && w[15:12] == PcIdx) w[15:12] = 4'($urandom_range(14));
    return w;
  endfunction

  // Seed registers through MOV/MVN immediates, then arithmetic, compares, conditional moves and TST
  task automatic test_directed();
    send_instr(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h0FF));
    send_instr(dp_word(CC_AL, 1'b1, OP_MVN, 1'b1, 4'd0, 4'd2, 12'h000));
    send_instr(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd3, 12'h102));
    send_instr(dp_word(CC_AL, 1'b1, OP_ADD, 1'b1, 4'd2, 4'd4, 12'h001));
    send_instr(dp_word(CC_AL, 1'b0, OP_SUB, 1'b1, 4'd1, 4'd5, 12'h002));
    send_instr(dp_word(CC_AL, 1'b1, OP_CMP, 1'b1, 4'd3, 4'd0, 12'h102));
    send_instr(dp_word(CC_LS, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd6, 12'h07F));
    send_instr(dp_word(CC_HI, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd6, 12'h001));
    send_instr(dp_word(CC_NV, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd6, 12'h001));
    send_instr(dp_word(CC_AL, 1'b1, OP_TST, 1'b0, 4'd2, 4'd0, 12'h001));
    // register shifts by 0, 32 and more than 32, then immediate RRX, ASR and LSR by 0
    send_instr(dp_word(CC_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd7, 12'h020));
    send_instr(dp_word(CC_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd8, 12'h0FF));
    send_instr(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, {4'd7, 4'b0001, 4'd2}));
    send_instr(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, {4'd8, 4'b0011, 4'd2}));
    send_instr(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, {4'd0, 4'b0101, 4'd2}));
    send_instr(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, {5'd0, 2'b11, 1'b0, 4'd2}));
    send_instr(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9, {5'd0, 2'b10, 1'b0, 4'd2}));
    send_instr(dp_word(CC_AL, 1'b0, OP_ADD, 1'b1, 4'd15, 4'd10, {5'd0, 2'b01, 1'b0, 4'd15}));
    // branches, link, write to PC, unsupported classes and a never-condition word
    send_instr(32'hEB00_0003);
    send_instr(32'hEAFF_FFFE);
    send_instr(32'hEA80_0000);
    send_instr(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'd0, PcIdx, 12'h040));
    send_instr(32'hE000_0091);
    send_instr(32'hE590_0000);
    send_instr(32'hFFFF_FFFF);
    drain();
  endtask

  // Random mix: mostly data processing, some branches and fully random words
  task automatic test_random(input int unsigned count);
    logic [31:0] w;
    int unsigned p;
    for (int unsigned i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 75) begin
        w = rand_dp();
      end else if (p < 85) begin
        w = $urandom();
        w[27:25] = 3'b101;
        if ($urandom_range(1)) w[31:28] = CC_AL;
      end else begin
        w = $urandom();
      end
      send_instr(w);
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    stall_hold = 1'b1;
    in_flood = 1'b1;
    test_random(40);
    in_flood = 1'b0;
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.instruction_word = '0;
    for (int i = 0; i < 16; i++) arch_regs[i] = '0;
    arch_nzcv = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(800);
    drain();
    test_backpressure();
    test_random(780);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/cabe_pkg.sv
design/cabe_if.sv
design/cabe_alu.sv
design/cond_alu_branch_executor_top.sv
tb/testbench.sv
